>>> rtl/utf8_byte_decoder_top_macros.svh
// assertion helpers for the checker file
`ifndef UTF8_BYTE_DECODER_TOP_MACROS_SVH
`define UTF8_BYTE_DECODER_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define U8D_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8d check failed");

// next-cycle implication, off while reset is held
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8d check failed");

`endif

>>> rtl/u8d_pkg.sv
package u8d_pkg;

    // byte ranges used by the decoder
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] CONT_E0_LO = 8'hA0;
    localparam logic [7:0] CONT_ED_HI = 8'h9F;
    localparam logic [7:0] CONT_F0_LO = 8'h90;
    localparam logic [7:0] CONT_F4_HI = 8'h8F;

    localparam int HELD_DEPTH = 3;

    // input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } u8d_in_t;

    // output request
    typedef struct packed {
        logic [20:0] code_point;
        logic        bad_byte;
        logic        run_last;
        logic        text_done;
    } u8d_out_t;

    // pending sequence state
    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held;
        logic [1:0]                 cnt;
        logic [2:0]                 len;
    } u8d_state_t;

    // all results of one input byte: held bytes as errors, then at most one final result
    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held;
        logic [1:0]                 n_flush;
        logic                       fin_valid;
        logic [20:0]                fin_cp;
        logic                       fin_bad;
        logic                       text_end;
        logic [2:0]                 count;
    } u8d_burst_t;

    // sequence length implied by a lead byte, zero when not a legal lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= LEAD2_LO && b <= LEAD2_HI)
            len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
            len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = 3'd4;
        return len;
    endfunction

    // legal continuation range, narrowed on the second byte for some leads
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (pos == 2'd1)
        begin
            if (lead == LEAD_E0)
                lo = CONT_E0_LO;
            else if (lead == LEAD_ED)
                hi = CONT_ED_HI;
            else if (lead == LEAD_F0)
                lo = CONT_F0_LO;
            else if (lead == LEAD_F4)
                hi = CONT_F4_HI;
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

>>> rtl/u8d_decode.sv
module u8d_decode (
    input  u8d_pkg::u8d_state_t st,
    input  u8d_pkg::u8d_in_t    item,
    output u8d_pkg::u8d_state_t st_next,
    output u8d_pkg::u8d_burst_t burst
);
    import u8d_pkg::*;

    logic [7:0]  b;
    logic        start;
    logic [2:0]  ll;
    logic [20:0] assembled;

    assign b = item.in_byte;

    // code point of a sequence completed by the current byte
    always_comb
    begin
        case (st.len)
            3'd2:    assembled = {10'd0, st.held[0][4:0], b[5:0]};
            3'd3:    assembled = {5'd0, st.held[0][3:0], st.held[1][5:0], b[5:0]};
            default: assembled = {st.held[0][2:0], st.held[1][5:0], st.held[2][5:0],
                                  b[5:0]};
        endcase
    end

    // one pass over the held sequence and the new byte
    always_comb
    begin
        st_next         = st;
        start           = 1'b0;
        ll              = lead_len(b);
        burst.held      = st.held;
        burst.n_flush   = 2'd0;
        burst.fin_valid = 1'b0;
        burst.fin_cp    = {13'd0, b};
        burst.fin_bad   = 1'b0;
        burst.text_end  = item.text_end;

        if (st.cnt == 2'd0)
            start = 1'b1;
        else if (cont_ok(st.held[0], st.cnt, b))
        begin
            if ({1'b0, st.cnt} + 3'd1 == st.len)
            begin
                // sequence complete
                burst.fin_valid = 1'b1;
                burst.fin_cp    = assembled;
                st_next.cnt     = 2'd0;
                st_next.len     = 3'd0;
            end
            else if (item.text_end)
            begin
                // text ends inside a sequence
                burst.n_flush   = st.cnt;
                burst.fin_valid = 1'b1;
                burst.fin_bad   = 1'b1;
                st_next.cnt     = 2'd0;
                st_next.len     = 3'd0;
            end
            else
            begin
                st_next.held[st.cnt] = b;
                st_next.cnt          = st.cnt + 2'd1;
            end
        end
        else
        begin
            // broken sequence: held bytes go out as errors, byte starts over
            burst.n_flush = st.cnt;
            start         = 1'b1;
        end

        if (start)
        begin
            st_next.cnt = 2'd0;
            st_next.len = 3'd0;
            if (!b[7])
                burst.fin_valid = 1'b1;
            else if (ll == 3'd0 || item.text_end)
            begin
                burst.fin_valid = 1'b1;
                burst.fin_bad   = 1'b1;
            end
            else
            begin
                st_next.held[0] = b;
                st_next.cnt     = 2'd1;
                st_next.len     = ll;
            end
        end

        burst.count = {1'b0, burst.n_flush} + {2'd0, burst.fin_valid};
    end

endmodule

>>> rtl/utf8_byte_decoder_top.sv
// utf8 byte decoder
// byte channel: byte_valid / byte_stall / byte_data carry one text byte per request,
// with text_end set on the last byte of a text.
// cp channel: cp_valid / cp_stall / cp_data carry one result per request: a code
// point, or a lone bad byte with bad_byte set. run_last marks the last result of an
// input byte, text_done the last result of the text.
// a byte is captured in an input register and then decoded into 0 to 4 results, which
// land in a result register and leave one per cycle while cp_stall is low.
// the first result of a byte passes the input register, then the result register,
// before it is on cp_data. throughput: one byte per cycle while each byte gives at
// most one result and cp_stall is low; a byte that gives several results holds the
// result register until its last result is taken, which sets the rate in error bursts.
// when cp_stall is high the current result holds; one more byte is still taken, if
// the input register is empty, then byte_stall rises until the result register drains.
// reset (rst_n low, asynchronous) empties both registers and drops any partial
// sequence; no clearing pass is needed.
module utf8_byte_decoder_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  u8d_pkg::u8d_in_t  byte_data,
    output logic              cp_valid,
    input  logic              cp_stall,
    output u8d_pkg::u8d_out_t cp_data
);
    import u8d_pkg::*;

    logic                       in_valid_reg;
    u8d_in_t                    in_item_reg;
    logic [HELD_DEPTH-1:0][7:0] held_reg;
    logic [1:0]                 cnt_reg;
    logic [2:0]                 len_reg;
    u8d_burst_t                 burst_reg;
    logic [2:0]                 burst_len_reg;
    logic [1:0]                 burst_idx_reg;

    u8d_state_t                 st;
    u8d_state_t                 st_next;
    u8d_burst_t                 burst_next;
    logic                       out_take;
    logic                       out_last;
    logic                       advance;
    logic                       in_take;

    assign st.held = held_reg;
    assign st.cnt  = cnt_reg;
    assign st.len  = len_reg;

    u8d_decode u_decode (
        .st      (st),
        .item    (in_item_reg),
        .st_next (st_next),
        .burst   (burst_next)
    );

    // handshake
    assign cp_valid   = (burst_len_reg != 3'd0);
    assign out_take   = cp_valid && !cp_stall;
    assign out_last   = ({1'b0, burst_idx_reg} == burst_len_reg - 3'd1);
    assign advance    = in_valid_reg && (!cp_valid || (out_take && out_last));
    assign byte_stall = in_valid_reg && !advance;
    assign in_take    = byte_valid && !byte_stall;

    // result selection from the result register
    always_comb
    begin
        if ({1'b0, burst_idx_reg} < {1'b0, burst_reg.n_flush})
        begin
            cp_data.code_point = {13'd0, burst_reg.held[burst_idx_reg]};
            cp_data.bad_byte   = 1'b1;
        end
        else
        begin
            cp_data.code_point = burst_reg.fin_cp;
            cp_data.bad_byte   = burst_reg.fin_bad;
        end
        cp_data.run_last  = out_last;
        cp_data.text_done = out_last && burst_reg.text_end;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= byte_data;
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end
        else if (advance)
        begin
            cnt_reg <= st_next.cnt;
            len_reg <= st_next.len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            held_reg <= st_next.held;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_len_reg <= 3'd0;
            burst_idx_reg <= 2'd0;
        end
        else if (advance)
        begin
            burst_len_reg <= burst_next.count;
            burst_idx_reg <= 2'd0;
        end
        else if (out_take)
        begin
            if (out_last)
                burst_len_reg <= 3'd0;
            else
                burst_idx_reg <= burst_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            burst_reg <= burst_next;
    end

endmodule

>>> rtl/u8d_checker.sv
module u8d_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input u8d_pkg::u8d_in_t  byte_data,
    input logic              cp_valid,
    input logic              cp_stall,
    input u8d_pkg::u8d_out_t cp_data
);
    import u8d_pkg::*;

`include "utf8_byte_decoder_top_macros.svh"

    logic byte_wait;
    logic cp_wide;
    logic cp_not_scalar;

    assign byte_wait     = byte_valid && byte_stall;
    assign cp_wide       = (cp_data.code_point[20:8] != 13'd0);
    // surrogate range or past the last plane
    assign cp_not_scalar = (cp_data.code_point[20:11] == 10'h01B) ||
                           (cp_data.code_point[20] && (cp_data.code_point[19:16] != 4'd0));

    // a stalled byte request holds
    `U8D_ASSERT_NEXT(a_in_hold, clk, rst_n, byte_wait, byte_valid && $stable(byte_data))

    // a stalled result holds
    `U8D_ASSERT_NEXT(a_cp_hold, clk, rst_n, cp_valid && cp_stall, cp_valid && $stable(cp_data))

    // end of text closes the byte's run
    `U8D_ASSERT_IMPLY(a_done_last, clk, rst_n, cp_valid && cp_data.text_done, cp_data.run_last)

    // error results carry a raw byte
    `U8D_ASSERT_IMPLY(a_bad_narrow, clk, rst_n, cp_valid && cp_data.bad_byte, !cp_wide)

    // decoded values are scalar values
    `U8D_ASSERT_IMPLY(a_scalar, clk, rst_n, cp_valid && !cp_data.bad_byte, !cp_not_scalar)

endmodule

bind utf8_byte_decoder_top u8d_checker u_u8d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp_data    (cp_data)
);
